// ===== rtl/core/ibh_pkg.sv =====
// ibh_pkg: shared codes and constants for the indexed binary heap
// no dependencies
`default_nettype none
package ibh_pkg;
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_CHANGE = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;
  localparam int ID_W = 10;
endpackage
`default_nettype wire

// ===== rtl/core/ibh_store.sv =====
// ibh_store: heap entry memory (key and id), one write and one read port
// depends on ibh_pkg
`default_nettype none
module ibh_store import ibh_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int KEY_WIDTH = 32,
  parameter int AW = 10
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [KEY_WIDTH-1:0] wkey,
  input  wire logic [ID_W-1:0]      wid,
  input  wire logic [AW-1:0]        raddr,
  output logic [KEY_WIDTH-1:0]      rkey,
  output logic [ID_W-1:0]           rid
);
  logic [KEY_WIDTH+ID_W-1:0] mem [DEPTH];
  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wkey, wid};
  end
  // registered read port
  always_ff @(posedge clk) begin
    {rkey, rid} <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/ibh_pos_store.sv =====
// ibh_pos_store: position-of-id memory, write only, kept for bookkeeping
// depends on ibh_pkg
`default_nettype none
module ibh_pos_store import ibh_pkg::*; #(
  parameter int AW = 10
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [ID_W-1:0] waddr,
  input  wire logic [AW-1:0]   wpos
);
  logic [AW-1:0] mem [2**ID_W];
  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wpos;
  end
endmodule
`default_nettype wire

// ===== rtl/core/indexed_binary_heap.sv =====
// indexed_binary_heap: top level, sequencer that sifts entries through the heap memory
// depends on ibh_pkg, ibh_store, ibh_pos_store
// One word at a time. From acceptance to result a word goes through fixed work
// (final up check, child reads and compare, root read and result), plus a read of
// the current entry for change key, and reads of the last and deleted entries and a
// write for delete; then per level climbed a parent read, compare and second write
// of the swap, and per level descended a re-entry, two child reads, compare and
// second write. Errors and the unused mode go straight to the root read and result.
// The single read and write port of the heap memory sets this pace.
// A finished result waits in the output register; the next word is taken once
// it is taken. The heap memory needs no clearing: only live positions are read.
`default_nettype none
module indexed_binary_heap import ibh_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_mode,
  input  wire logic [9:0]           in_position,
  input  wire logic [9:0]           in_item_id,
  input  wire logic [KEY_WIDTH-1:0] in_key,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [9:0]                out_final_position,
  output logic [10:0]               out_heap_size,
  output logic                      out_top_valid,
  output logic [9:0]                out_top_id,
  output logic [KEY_WIDTH-1:0]      out_top_key,
  output logic [1:0]                out_error,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_max_first
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEL_RD, S_DEL_WR, S_RD_CUR, S_UP_RD, S_UP_CMP, S_DN_RD_L,
    S_DN_RD_R, S_DN_CMP, S_SWAP2, S_TOP_RD, S_TOP_WAIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic max_first_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [KEY_WIDTH-1:0] ckey_r, ckey_nxt;
  logic [ID_W-1:0] cid_r, cid_nxt;
  logic [AW-1:0] oth_r, oth_nxt;
  logic [KEY_WIDTH-1:0] okey_r, okey_nxt;
  logic [ID_W-1:0] oid_r, oid_nxt;
  logic up_phase_r, up_phase_nxt;
  logic lhas_r, lhas_nxt;
  logic [AW-1:0] fpos_r, fpos_nxt;
  logic [1:0] err_r, err_nxt;
  logic ov_r, ov_nxt;
  logic [9:0] of_r, of_nxt;
  logic [10:0] os_r, os_nxt;
  logic ot_r, ot_nxt;
  logic [9:0] oi_r, oi_nxt;
  logic [KEY_WIDTH-1:0] ok_r, ok_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [KEY_WIDTH-1:0] wkey, rkey;
  logic [ID_W-1:0] wid, rid;
  logic pwe;
  logic [ID_W-1:0] paddr;
  logic [AW-1:0] pwpos;

  ibh_store #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wkey(wkey), .wid(wid),
    .raddr(raddr), .rkey(rkey), .rid(rid)
  );
  ibh_pos_store #(.AW(AW)) u_pos (
    .clk(clk), .we(pwe), .waddr(paddr), .wpos(pwpos)
  );

  // b must sit above a
  function automatic logic beats(logic mf, logic [KEY_WIDTH-1:0] a,
                                 logic [KEY_WIDTH-1:0] b);
    return mf ? (a < b) : (a > b);
  endfunction

  logic [CW:0] lchild, rchild;
  logic [AW-1:0] parent;
  always_comb begin
    lchild = (CW+1)'({cur_r, 1'b1});
    rchild = lchild + 1'b1;
    parent = (cur_r - 1'b1) >> 1;
  end

  // requested position lies below the entry count
  logic pos_ok;
  assign pos_ok = (CW+10)'(in_position) < (CW+10)'(count_r);

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_final_position = of_r;
  assign out_heap_size = os_r;
  assign out_top_valid = ot_r;
  assign out_top_id = oi_r;
  assign out_top_key = ok_r;

  // sequencer
  always_comb begin
    state_nxt = state_r; count_nxt = count_r; cur_nxt = cur_r;
    ckey_nxt = ckey_r; cid_nxt = cid_r; oth_nxt = oth_r;
    okey_nxt = okey_r; oid_nxt = oid_r; up_phase_nxt = up_phase_r;
    lhas_nxt = lhas_r; fpos_nxt = fpos_r; err_nxt = err_r;
    ov_nxt = ov_r; of_nxt = of_r; os_nxt = os_r; ot_nxt = ot_r;
    oi_nxt = oi_r; ok_nxt = ok_r;
    we = 1'b0; waddr = cur_r; wkey = ckey_r; wid = cid_r;
    raddr = cur_r;
    pwe = 1'b0; paddr = cid_r; pwpos = cur_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          err_nxt = ERR_OK; fpos_nxt = '0;
          cur_nxt = AW'(in_position);
          ckey_nxt = in_key; cid_nxt = in_item_id;
          up_phase_nxt = 1'b1;
          state_nxt = S_TOP_RD;
          case (in_mode)
            MODE_INSERT: begin
              if (count_r >= CW'(DEPTH)) err_nxt = ERR_FULL;
              else begin
                we = 1'b1; waddr = count_r[AW-1:0];
                wkey = in_key; wid = in_item_id;
                pwe = 1'b1; paddr = in_item_id; pwpos = count_r[AW-1:0];
                cur_nxt = count_r[AW-1:0];
                count_nxt = count_r + 1'b1;
                state_nxt = S_UP_RD;
              end
            end
            MODE_CHANGE: begin
              if (!pos_ok) err_nxt = ERR_RANGE;
              else begin
                raddr = AW'(in_position);
                state_nxt = S_RD_CUR;
              end
            end
            MODE_DELETE: begin
              if (!pos_ok) err_nxt = ERR_RANGE;
              else begin
                raddr = AW'(count_r - 1'b1);
                state_nxt = S_DEL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      // last entry read; fetch the deleted one
      S_DEL_RD: begin
        okey_nxt = rkey; oid_nxt = rid;
        raddr = cur_r;
        state_nxt = S_DEL_WR;
      end
      S_DEL_WR: begin
        count_nxt = count_r - 1'b1;
        we = 1'b1; waddr = AW'(count_r - 1'b1); wkey = rkey; wid = rid;
        if (CW'(cur_r) == count_r - 1'b1) state_nxt = S_TOP_RD;
        else begin
          state_nxt = S_SWAP2;
          ckey_nxt = okey_r; cid_nxt = oid_r;
          oth_nxt = cur_r; up_phase_nxt = 1'b1;
          pwe = 1'b1; paddr = rid; pwpos = AW'(count_r - 1'b1);
        end
      end
      // changed entry: keep id, take new key
      S_RD_CUR: begin
        cid_nxt = rid;
        we = 1'b1; wkey = ckey_r; wid = rid;
        state_nxt = S_UP_RD;
      end
      S_UP_RD: begin
        if (up_phase_r && cur_r != '0) begin
          raddr = parent; oth_nxt = parent; state_nxt = S_UP_CMP;
        end else begin
          up_phase_nxt = 1'b0;
          state_nxt = S_DN_RD_L;
        end
      end
      S_UP_CMP: begin
        if (beats(max_first_r, rkey, ckey_r)) begin
          okey_nxt = rkey; oid_nxt = rid;
          we = 1'b1; waddr = cur_r; wkey = rkey; wid = rid;
          pwe = 1'b1; paddr = rid; pwpos = cur_r;
          state_nxt = S_SWAP2;
        end else begin
          up_phase_nxt = 1'b0; state_nxt = S_DN_RD_L;
        end
      end
      // second half of a swap: current entry lands at the other slot
      S_SWAP2: begin
        we = 1'b1; waddr = oth_r; wkey = ckey_r; wid = cid_r;
        pwe = 1'b1; paddr = cid_r; pwpos = oth_r;
        cur_nxt = oth_r;
        state_nxt = S_UP_RD;
      end
      S_DN_RD_L: begin
        raddr = lchild[AW-1:0];
        if (lchild < (CW+1)'(count_r)) state_nxt = S_DN_RD_R;
        else begin
          fpos_nxt = cur_r; state_nxt = S_TOP_RD;
        end
      end
      S_DN_RD_R: begin
        raddr = rchild[AW-1:0];
        lhas_nxt = beats(max_first_r, ckey_r, rkey);
        okey_nxt = rkey; oid_nxt = rid; oth_nxt = lchild[AW-1:0];
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (rchild < (CW+1)'(count_r) &&
            beats(max_first_r, lhas_r ? okey_r : ckey_r, rkey)) begin
          okey_nxt = rkey; oid_nxt = rid; oth_nxt = rchild[AW-1:0];
          we = 1'b1; wkey = rkey; wid = rid;
          pwe = 1'b1; paddr = rid; pwpos = cur_r;
          state_nxt = S_SWAP2;
        end else if (lhas_r) begin
          we = 1'b1; wkey = okey_r; wid = oid_r;
          pwe = 1'b1; paddr = oid_r; pwpos = cur_r;
          state_nxt = S_SWAP2;
        end else begin
          fpos_nxt = cur_r; state_nxt = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        raddr = '0; state_nxt = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        raddr = '0; state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          of_nxt = 10'(fpos_r);
          os_nxt = 11'(count_r);
          ot_nxt = count_r != '0;
          oi_nxt = count_r != '0 ? rid : '0;
          ok_nxt = count_r != '0 ? rkey : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [1:0] oe_r;
  assign out_error = oe_r;

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; ov_r <= 1'b0; max_first_r <= 1'b1;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; ov_r <= ov_nxt;
      if (cfg_valid) max_first_r <= cfg_max_first;
    end
    cur_r <= cur_nxt; ckey_r <= ckey_nxt; cid_r <= cid_nxt; oth_r <= oth_nxt;
    okey_r <= okey_nxt; oid_r <= oid_nxt; up_phase_r <= up_phase_nxt;
    lhas_r <= lhas_nxt; fpos_r <= fpos_nxt; err_r <= err_nxt;
    of_r <= of_nxt; os_r <= os_nxt; ot_r <= ot_nxt; oi_r <= oi_nxt; ok_r <= ok_nxt;
    if (state_r == S_DONE && !ov_r) oe_r <= err_r;
  end
endmodule
`default_nettype wire

// ===== rtl/core/ibh_checker.sv =====
// ibh_checker: port-level checks on the heap top level
// depends on indexed_binary_heap (bound to it)
`default_nettype none
module ibh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [10:0] out_heap_size,
  input wire logic        out_top_valid,
  input wire logic [1:0]  out_error
);
  // an empty heap shows no top
  a_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_valid == (out_heap_size != 11'd0)))
    else $error("top_valid disagrees with heap size");
  // no word taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("word taken with result pending");
  // error codes stay in range
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error != 2'd3) else $error("bad error code");
  // result held until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heap_size))
    else $error("result dropped");
endmodule
bind indexed_binary_heap ibh_checker u_ibh_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_heap_size(out_heap_size),
  .out_top_valid(out_top_valid), .out_error(out_error)
);
`default_nettype wire
